### rtl/spt_pkg.sv
// Shared types, codes and constants for the sampling parameter tuner.
package spt_pkg;

	// Configuration port geometry
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 16;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_RUN_MODE     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_STRATEGY     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TEMP_FLOOR   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_TEMP_CEILING = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_TOPK_FLOOR   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_TOPK_CEILING = 3'd5;

	// Run modes (code 3 behaves as observe)
	localparam logic [1:0] MODE_OFF     = 2'd0;
	localparam logic [1:0] MODE_OBSERVE = 2'd1;
	localparam logic [1:0] MODE_ENFORCE = 2'd2;

	// Tuning strategies (codes 5..7 behave as none)
	localparam logic [2:0] STRAT_NONE    = 3'd0;
	localparam logic [2:0] STRAT_ENTROPY = 3'd1;
	localparam logic [2:0] STRAT_LENGTH  = 3'd2;
	localparam logic [2:0] STRAT_QUALITY = 3'd3;
	localparam logic [2:0] STRAT_HYBRID  = 3'd4;

	// Request functions
	localparam logic FUNC_SAMPLE = 1'b0;
	localparam logic FUNC_CLEAR  = 1'b1;

	// Reset values
	localparam logic [15:0] RST_TEMP_FLOOR   = 16'd100;
	localparam logic [15:0] RST_TEMP_CEILING = 16'd1500;
	localparam logic [9:0]  RST_TOPK_FLOOR   = 10'd1;
	localparam logic [9:0]  RST_TOPK_CEILING = 10'd100;
	localparam logic [15:0] RST_TEMP_REC     = 16'd700;
	localparam logic [9:0]  RST_TOPK_REC     = 10'd40;

	// Response length classes
	localparam logic [15:0] SHORT_LIMIT = 16'd20;
	localparam logic [15:0] LONG_LIMIT  = 16'd60;

	// Entropy thresholds, on the average and on 5x the average (pre-divide sum)
	localparam logic [15:0] ENT_LOW       = 16'd500;
	localparam logic [15:0] ENT_HIGH      = 16'd1500;
	localparam logic [18:0] ENT_LOW_X5    = 19'd2500;  // avg <  500  <=> sum < 2500
	localparam logic [18:0] ENT_HIGH_X5   = 19'd7504;  // avg > 1500  <=> sum > 7504

	// Divide by 5 via reciprocal: floor(x * 419431 / 2^21), exact for x < 699050
	localparam logic [19:0] DIV5_RECIP = 20'd419431;
	localparam int unsigned DIV5_SHIFT = 21;

	// Adjustment steps
	localparam logic [16:0] TEMP_MIN_DEC  = 17'd100;
	localparam logic [16:0] TEMP_STEP_ENT = 17'd50;
	localparam logic [16:0] TEMP_STEP_LEN = 17'd30;
	localparam logic [16:0] TEMP_STEP_QLT = 17'd100;
	localparam logic [10:0] TOPK_STEP_LEN = 11'd5;
	localparam logic [10:0] TOPK_STEP_QLT = 11'd10;
	localparam logic [15:0] REP_LIMIT_QLT = 16'd3;
	localparam logic [15:0] REP_LIMIT_HYB = 16'd2;

	typedef struct packed {
		logic [1:0]  run_mode;
		logic [2:0]  strategy;
		logic [15:0] temp_floor;
		logic [15:0] temp_ceiling;
		logic [9:0]  topk_floor;
		logic [9:0]  topk_ceiling;
	} cfg_t;

	typedef struct packed {
		logic        func;
		logic [15:0] token_count;
		logic [15:0] repeat_count;
		logic [15:0] entropy_sample;
	} item_t;

	typedef struct packed {
		logic [15:0] rec_temperature;
		logic [9:0]  rec_topk;
		logic [15:0] entropy_average;
		logic [31:0] samples_seen;
		logic [31:0] short_seen;
		logic [31:0] long_seen;
		logic [31:0] tokens_sum;
		logic [31:0] repeats_sum;
		logic [31:0] adjustments_done;
	} stats_t;

endpackage

### rtl/spt_cfg.sv
// Configuration register file for the sampling parameter tuner.
module spt_cfg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [spt_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [spt_pkg::CFG_DATA_W-1:0] cfg_data,
	output spt_pkg::cfg_t                 cfg
);
	import spt_pkg::*;

	cfg_t cfg_q;

	// Register writes; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.run_mode     <= MODE_OFF;
			cfg_q.strategy     <= STRAT_NONE;
			cfg_q.temp_floor   <= RST_TEMP_FLOOR;
			cfg_q.temp_ceiling <= RST_TEMP_CEILING;
			cfg_q.topk_floor   <= RST_TOPK_FLOOR;
			cfg_q.topk_ceiling <= RST_TOPK_CEILING;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_RUN_MODE:     cfg_q.run_mode     <= cfg_data[1:0];
				REG_STRATEGY:     cfg_q.strategy     <= cfg_data[2:0];
				REG_TEMP_FLOOR:   cfg_q.temp_floor   <= cfg_data;
				REG_TEMP_CEILING: cfg_q.temp_ceiling <= cfg_data;
				REG_TOPK_FLOOR:   cfg_q.topk_floor   <= cfg_data[9:0];
				REG_TOPK_CEILING: cfg_q.topk_ceiling <= cfg_data[9:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

### rtl/spt_core.sv
// Statistics and recommendation update: state registers double as the result register.
module spt_core (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           load,
	input  spt_pkg::item_t item,
	input  spt_pkg::cfg_t  cfg,
	output spt_pkg::stats_t stats
);
	import spt_pkg::*;

	stats_t st_q;
	stats_t st_n;

	logic [18:0] avg_sum;
	logic [38:0] avg_prod;
	logic [15:0] avg_div;

	// avg*4 + sample, then divide by 5 through the reciprocal multiplier
	assign avg_sum  = {1'b0, st_q.entropy_average, 2'b00} + {3'b000, item.entropy_sample};
	assign avg_prod = avg_sum * DIV5_RECIP;
	assign avg_div  = avg_prod[DIV5_SHIFT+15:DIV5_SHIFT];

	// Next state for one request
	always_comb begin
		logic        seed;
		logic        avg_low;
		logic        avg_high;
		logic [16:0] t;
		logic [10:0] k;

		st_n     = st_q;
		seed     = (st_q.samples_seen == '0);
		avg_low  = seed ? (item.entropy_sample < ENT_LOW) : (avg_sum < ENT_LOW_X5);
		avg_high = seed ? (item.entropy_sample > ENT_HIGH) : (avg_sum > ENT_HIGH_X5);
		t        = {1'b0, st_q.rec_temperature};
		k        = {1'b0, st_q.rec_topk};

		if (item.func == FUNC_CLEAR) begin
			st_n.samples_seen    = '0;
			st_n.tokens_sum      = '0;
			st_n.repeats_sum     = '0;
			st_n.short_seen      = '0;
			st_n.long_seen       = '0;
			st_n.entropy_average = '0;
		end else if (cfg.run_mode != MODE_OFF) begin
			st_n.samples_seen    = st_q.samples_seen + 32'd1;
			st_n.tokens_sum      = st_q.tokens_sum + {16'd0, item.token_count};
			st_n.repeats_sum     = st_q.repeats_sum + {16'd0, item.repeat_count};
			st_n.entropy_average = seed ? item.entropy_sample : avg_div;
			if (item.token_count < SHORT_LIMIT) begin
				st_n.short_seen = st_q.short_seen + 32'd1;
			end else if (item.token_count > LONG_LIMIT) begin
				st_n.long_seen = st_q.long_seen + 32'd1;
			end

			if (cfg.run_mode == MODE_ENFORCE) begin
				// Strategy nudge
				case (cfg.strategy)
					STRAT_ENTROPY: begin
						if (avg_low) begin
							t = t + TEMP_STEP_ENT;
						end else if (avg_high && t > TEMP_MIN_DEC) begin
							t = t - TEMP_STEP_ENT;
						end
					end
					STRAT_LENGTH: begin
						if (st_n.short_seen > st_n.long_seen) begin
							t = t + TEMP_STEP_LEN;
							k = k + TOPK_STEP_LEN;
						end else if (st_n.long_seen > st_n.short_seen) begin
							if (t > TEMP_MIN_DEC) t = t - TEMP_STEP_LEN;
							if (k > TOPK_STEP_LEN) k = k - TOPK_STEP_LEN;
						end
					end
					STRAT_QUALITY: begin
						if (item.repeat_count > REP_LIMIT_QLT) begin
							t = t + TEMP_STEP_QLT;
							k = k + TOPK_STEP_QLT;
						end
					end
					STRAT_HYBRID: begin
						if (avg_low || item.repeat_count > REP_LIMIT_HYB) t = t + TEMP_STEP_ENT;
						if (st_n.short_seen > (st_n.samples_seen >> 1)) k = k + TOPK_STEP_LEN;
					end
					default: ;
				endcase

				// Clamp: floor first, ceiling wins
				if (t < {1'b0, cfg.temp_floor})   t = {1'b0, cfg.temp_floor};
				if (t > {1'b0, cfg.temp_ceiling}) t = {1'b0, cfg.temp_ceiling};
				if (k < {1'b0, cfg.topk_floor})   k = {1'b0, cfg.topk_floor};
				if (k > {1'b0, cfg.topk_ceiling}) k = {1'b0, cfg.topk_ceiling};

				st_n.rec_temperature  = t[15:0];
				st_n.rec_topk         = k[9:0];
				st_n.adjustments_done = st_q.adjustments_done + 32'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '{rec_temperature: RST_TEMP_REC, rec_topk: RST_TOPK_REC,
			          entropy_average: 16'd0, samples_seen: 32'd0, short_seen: 32'd0,
			          long_seen: 32'd0, tokens_sum: 32'd0, repeats_sum: 32'd0,
			          adjustments_done: 32'd0};
		end else if (load) begin
			st_q <= st_n;
		end
	end

	assign stats = st_q;

endmodule

### rtl/sampling_param_tuner_unit.sv
// Top level of the sampling parameter tuner.
//
// Input channel: in_valid / in_stall with func, token_count, repeat_count and
// entropy_sample. func selects between feeding one response sample and
// clearing the running statistics. Every request yields exactly one result on
// the output channel (out_valid / out_stall): the recommended temperature and
// top-k plus all running statistics after that request.
// A request accepted on the input channel is captured in the input register,
// and its result is loaded into the state/result registers when the result
// register can advance, which raises out_valid.
// Throughput: one request per cycle unless the receiver stalls; the update
// (divide-by-5 reciprocal multiply, strategy nudge, clamp) is combinational.
// When the receiver stalls, the result holds and the input register keeps
// one more request; in_stall rises only while both are full and stalled.
// Configuration is a plain write port (cfg_we, cfg_index, cfg_data); the user
// must write it only while the block is idle; the block does not enforce this.
// Reset clears the statistics, sets temperature 700 and top-k 40, loads the
// register defaults and empties both stages.
module sampling_param_tuner_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [spt_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [spt_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          func,
	input  logic [15:0]                   token_count,
	input  logic [15:0]                   repeat_count,
	input  logic [15:0]                   entropy_sample,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [15:0]                   rec_temperature,
	output logic [9:0]                    rec_topk,
	output logic [15:0]                   entropy_average,
	output logic [31:0]                   samples_seen,
	output logic [31:0]                   short_seen,
	output logic [31:0]                   long_seen,
	output logic [31:0]                   tokens_sum,
	output logic [31:0]                   repeats_sum,
	output logic [31:0]                   adjustments_done
);
	import spt_pkg::*;

	cfg_t   cfg;
	item_t  item_s1;
	logic   valid_s1;
	logic   out_valid_q;
	logic   advance;
	stats_t stats;

	// Handshake: result register can take the held request unless it is stalled
	assign advance  = valid_s1 & ~(out_valid_q & out_stall);
	assign in_stall = valid_s1 & out_valid_q & out_stall;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1 <= '{func: func, token_count: token_count,
			             repeat_count: repeat_count, entropy_sample: entropy_sample};
		end
	end

	// Result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	spt_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	spt_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (advance),
		.item   (item_s1),
		.cfg    (cfg),
		.stats  (stats)
	);

	assign out_valid        = out_valid_q;
	assign rec_temperature  = stats.rec_temperature;
	assign rec_topk         = stats.rec_topk;
	assign entropy_average  = stats.entropy_average;
	assign samples_seen     = stats.samples_seen;
	assign short_seen       = stats.short_seen;
	assign long_seen        = stats.long_seen;
	assign tokens_sum       = stats.tokens_sum;
	assign repeats_sum      = stats.repeats_sum;
	assign adjustments_done = stats.adjustments_done;

endmodule

### rtl/spt_checker.sv
// Port-level checker for the sampling parameter tuner, bound to the top level.
module spt_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [15:0] rec_temperature,
	input logic [9:0]  rec_topk,
	input logic [31:0] samples_seen,
	input logic [31:0] adjustments_done
);

	// Stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(rec_temperature) &&
		$stable(rec_topk) && $stable(samples_seen) && $stable(adjustments_done))
		else $error("stalled result changed");

	// Input backpressure only while a result is held by the receiver
	a_in_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without output backpressure");

	// At most one request retires per cycle: sample count holds, steps by one or clears
	a_sample_step: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall |=> samples_seen == $past(samples_seen) ||
		samples_seen == 32'($past(samples_seen) + 32'd1) || samples_seen == '0)
		else $error("sample count jumped");

	// Adjustment count never clears and steps by at most one
	a_adjust_step: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall |=> adjustments_done == $past(adjustments_done) ||
		adjustments_done == 32'($past(adjustments_done) + 32'd1))
		else $error("adjustment count jumped");

endmodule

bind sampling_param_tuner_unit spt_checker u_spt_checker (.*);
